// ===== rtl/hsfc_pkg.sv =====
// hsfc_pkg: constants and types shared by the half/single converter
// no dependencies
`default_nettype none
package hsfc_pkg;
   localparam int unsigned HalfW   = 16;
   localparam int unsigned SingleW = 32;
   localparam logic [4:0]  HExpMax = 5'h1F;
   localparam logic [7:0]  SExpMax = 8'hFF;
   localparam logic [7:0]  Rebias  = 8'd112;
   localparam logic [9:0]  HQnan   = 10'h200;

   typedef enum logic {
      FUNC_H2S = 1'b0,
      FUNC_S2H = 1'b1
   } func_type;

   typedef struct packed {
      logic               func;
      logic [HalfW-1:0]   half_in;
      logic [SingleW-1:0] single_in;
   } req_type;

   typedef struct packed {
      logic [SingleW-1:0] single_out;
      logic [HalfW-1:0]   half_out;
   } rsp_type;
endpackage
`default_nettype wire

// ===== rtl/hsfc_if.sv =====
// hsfc_if: valid/ready channel carrying one request or one response
// depends on hsfc_pkg for the payload types
`default_nettype none
interface hsfc_req_if import hsfc_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface hsfc_rsp_if import hsfc_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/half_single_float_converter.sv =====
// half_single_float_converter: binary16 <-> binary32 conversion, four stages
// depends on hsfc_pkg and hsfc_if
//
//  channel  dir  handshake       payload
//  req      in   valid / ready   func, half_in, single_in
//  rsp      out  valid / ready   single_out, half_out
//
// one request per cycle while rsp is ready or stage 4 is empty; the rate is set by the stage chain
// s1 decodes and counts leading zeros, s2 aligns, s3 rounds, s4 packs
// all stages advance together; rsp not ready holds every full stage
// reset clears the stage valid bits only
`default_nettype none
module half_single_float_converter import hsfc_pkg::*; (
   input wire logic   clock,
   input wire logic   reset,
   hsfc_req_if.sink   req,
   hsfc_rsp_if.source rsp
);
   logic adv;
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic v1_in, v2_in, v3_in, v4_in;

   assign adv = ~v4_ff | rsp.ready;
   assign req.ready = adv;
   assign v1_in = req.valid;
   assign v2_in = v1_ff;
   assign v3_in = v2_ff;
   assign v4_in = v3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0; v4_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= v1_in; v2_ff <= v2_in; v3_ff <= v3_in; v4_ff <= v4_in;
      end
   end

   // stage 1: decode
   typedef struct packed {
      logic        func;
      logic        sign;
      logic        special;   // h2s zero/inf/nan, or s2h inf/nan/zero/ovf/underflow
      logic [31:0] spec_val;
      logic [9:0]  hm;
      logic [3:0]  lz;
      logic [4:0]  he;
      logic [23:0] sm;        // single mantissa with hidden bit
      logic [4:0]  sh;        // right shift for s2h (13 .. 24)
      logic [4:0]  hexp;      // biased half exponent (0 for subnormal)
   } s1_type;
   s1_type s1_in, s1_ff;

   always_comb begin
      logic [7:0] e8;
      logic [8:0] e;
      logic [15:0] hs;
      s1_in = '0;
      s1_in.func = req.data.func;
      e8 = req.data.single_in[30:23];
      e = {1'b0, e8} - 9'd112;
      hs = {req.data.single_in[31], 15'd0};
      s1_in.hm = req.data.half_in[9:0];
      s1_in.he = req.data.half_in[14:10];
      s1_in.sm = {1'b1, req.data.single_in[22:0]};
      s1_in.lz = 4'd10;
      for (int i = 0; i < 10; i++)
         if (req.data.half_in[i]) s1_in.lz = 4'(9 - i);
      if (req.data.func == FUNC_H2S) begin
         s1_in.sign = req.data.half_in[15];
         if (req.data.half_in[14:0] == 15'd0) begin
            s1_in.special = 1'b1;
            s1_in.spec_val = {req.data.half_in[15], 31'd0};
         end else if (req.data.half_in[14:10] == HExpMax) begin
            s1_in.special = 1'b1;
            s1_in.spec_val = {req.data.half_in[15], SExpMax, req.data.half_in[9:0], 13'd0};
         end
      end else begin
         s1_in.sign = req.data.single_in[31];
         if (e8 == SExpMax) begin
            s1_in.special = 1'b1;
            s1_in.spec_val = {16'd0, hs | {1'b0, HExpMax,
                              (req.data.single_in[22:0] != 23'd0) ? HQnan : 10'd0}};
         end else if (e8 == 8'd0 || e8 < 8'd102) begin
            s1_in.special = 1'b1;
            s1_in.spec_val = {16'd0, hs};
         end else if (e8 >= 8'd143) begin
            s1_in.special = 1'b1;
            s1_in.spec_val = {16'd0, hs | {1'b0, HExpMax, 10'd0}};
         end else if (e8 <= 8'd112) begin
            // subnormal: shift 14 - (e8-112) = 126 - e8
            s1_in.sh = 5'(8'd126 - e8);
            s1_in.hexp = 5'd0;
         end else begin
            s1_in.sh = 5'd13;
            s1_in.hexp = e[4:0];
         end
      end
   end

   always_ff @(posedge clock) if (adv) s1_ff <= s1_in;

   // stage 2: align
   typedef struct packed {
      logic        func;
      logic        sign;
      logic        special;
      logic [31:0] spec_val;
      logic [31:0] h2s;
      logic [10:0] m;
      logic        rb;
      logic        sticky;
      logic [4:0]  hexp;
   } s2_type;
   s2_type s2_in, s2_ff;

   always_comb begin
      logic [47:0] w;
      logic [9:0]  nm;
      logic [7:0]  ne;
      s2_in.func = s1_ff.func;
      s2_in.sign = s1_ff.sign;
      s2_in.special = s1_ff.special;
      s2_in.spec_val = s1_ff.spec_val;
      s2_in.hexp = s1_ff.hexp;
      if (s1_ff.he == 5'd0) begin
         // subnormal half: exponent 1 - (lz + 1), rebased to single
         nm = 10'(s1_ff.hm << (s1_ff.lz + 4'd1));
         ne = Rebias - {4'd0, s1_ff.lz};
      end else begin
         nm = s1_ff.hm;
         ne = {3'd0, s1_ff.he} + Rebias;
      end
      s2_in.h2s = {s1_ff.sign, ne, nm, 13'd0};
      w = {s1_ff.sm, 24'd0} >> s1_ff.sh;
      s2_in.m = w[34:24];
      s2_in.rb = w[23];
      s2_in.sticky = |w[22:0];
   end

   always_ff @(posedge clock) if (adv) s2_ff <= s2_in;

   // stage 3: round
   typedef struct packed {
      logic        func;
      logic        sign;
      logic        special;
      logic [31:0] spec_val;
      logic [31:0] h2s;
      logic [15:0] sum;
   } s3_type;
   s3_type s3_in, s3_ff;

   always_comb begin
      logic up;
      logic [15:0] base;
      s3_in.func = s2_ff.func;
      s3_in.sign = s2_ff.sign;
      s3_in.special = s2_ff.special;
      s3_in.spec_val = s2_ff.spec_val;
      s3_in.h2s = s2_ff.h2s;
      up = s2_ff.rb & (s2_ff.sticky | s2_ff.m[0]);
      // normal: exponent plus fraction, carry out of fraction bumps exponent
      if (s2_ff.hexp == 5'd0)
         base = {5'd0, s2_ff.m};
      else
         base = {1'b0, s2_ff.hexp, s2_ff.m[9:0]};
      s3_in.sum = base + {15'd0, up};
   end

   always_ff @(posedge clock) if (adv) s3_ff <= s3_in;

   // stage 4: pack
   rsp_type out_in, out_ff;
   always_comb begin
      out_in = '0;
      if (s3_ff.func == FUNC_H2S) begin
         out_in.single_out = s3_ff.special ? s3_ff.spec_val : s3_ff.h2s;
      end else if (s3_ff.special) begin
         out_in.half_out = s3_ff.spec_val[15:0];
      end else if (s3_ff.sum[14:10] == HExpMax) begin
         out_in.half_out = {s3_ff.sign, HExpMax, 10'd0};
      end else begin
         out_in.half_out = {s3_ff.sign, s3_ff.sum[14:0]};
      end
   end

   always_ff @(posedge clock) if (adv) out_ff <= out_in;

   assign rsp.valid = v4_ff;
   assign rsp.data  = out_ff;
endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// tb_top: self-checking testbench for half_single_float_converter
// depends on hsfc_pkg, hsfc_if and the converter rtl
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
   import hsfc_pkg::*;

   localparam int NumRandom  = 900;
   localparam int CycleLimit = 200000;

   logic clock;
   logic reset;
   hsfc_req_if req_ch ();
   hsfc_rsp_if rsp_ch ();

   half_single_float_converter dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source)
   );

   rsp_type conv_expected_q[$];
   int      fail_count;
   int      rsp_count;
   int      cycle_count;
   bit      hold_off;
   bit      quiet_stretch;

   // half to single, exact
   function automatic logic [31:0] widen_half(logic [15:0] h);
      logic [31:0] sgn;
      logic [4:0]  ex;
      logic [9:0]  man;
      int          e;
      sgn = {h[15], 31'b0};
      ex  = h[14:10];
      man = h[9:0];
      if (ex == 5'd0) begin
         if (man == 10'd0) return sgn;
         e = 1;
         while (man[9] == 1'b0) begin
            man = man << 1;
            e--;
         end
         // one more shift drops the leading one
         man = man << 1;
         e--;
         return sgn | (32'(e + 112) << 23) | (32'(man) << 13);
      end
      if (ex == 5'h1F) return sgn | 32'h7F80_0000 | (32'(man) << 13);
      return sgn | (32'(int'(ex) + 112) << 23) | (32'(man) << 13);
   endfunction

   // single to half, round to nearest even
   function automatic logic [15:0] narrow_single(logic [31:0] b);
      logic [15:0] sgn;
      logic [7:0]  e8;
      logic [23:0] m24;
      logic [31:0] m, rest, rb;
      int          e, sh;
      sgn = {b[31], 15'b0};
      e8  = b[30:23];
      m24 = {1'b0, b[22:0]};
      if (e8 == 8'hFF) return sgn | 16'h7C00 | (m24 != 0 ? 16'h0200 : 16'h0);
      if (e8 == 8'h00) return sgn;
      e = int'(e8) - 127 + 15;
      if (e >= 31) return sgn | 16'h7C00;
      if (e <= 0) begin
         if (e < -10) return sgn;
         m24[23] = 1'b1;
         sh   = 14 - e;
         m    = 32'(m24) >> sh;
         rb   = 32'd1 << (sh - 1);
         rest = 32'(m24) & ((rb << 1) - 1);
         if (rest > rb || (rest == rb && m[0])) m++;
         return sgn | m[15:0];
      end
      m    = 32'(m24) >> 13;
      rest = 32'(m24) & 32'h1FFF;
      if (rest > 32'h1000 || (rest == 32'h1000 && m[0])) begin
         m++;
         if (m == 32'h400) begin
            m = 0;
            e++;
            if (e >= 31) return sgn | 16'h7C00;
         end
      end
      return sgn | 16'(e << 10) | m[15:0];
   endfunction

   function automatic rsp_type convert(req_type r);
      rsp_type o;
      o = '0;
      if (r.func == FUNC_H2S) o.single_out = widen_half(r.half_in);
      else o.half_out = narrow_single(r.single_in);
      return o;
   endfunction

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CycleLimit) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Verification failed");
            $finish;
         end
      end
   end

   // response side: random stall plus one long hold-off
   initial begin
      int n;
      rsp_ch.ready = 1'b0;
      hold_off = 1'b0;
      @(negedge reset);
      n = 0;
      forever begin
         @(posedge clock);
         n++;
         if (n == 200) hold_off = 1'b1;
         if (n == 260) hold_off = 1'b0;
         if (hold_off) rsp_ch.ready <= 1'b0;
         else if (quiet_stretch) rsp_ch.ready <= 1'b1;
         else rsp_ch.ready <= ($urandom_range(99) >= 23);
      end
   end

   // response checker
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         rsp_count++;
         if (conv_expected_q.size() == 0) begin
            $error("unexpected response %h", rsp_ch.data);
            fail_count++;
         end else begin
            want = conv_expected_q.pop_front();
            if (rsp_ch.data.single_out !== want.single_out) begin
               $error("single_out expected %h actual %h", want.single_out,
                      rsp_ch.data.single_out);
               fail_count++;
            end
            if (rsp_ch.data.half_out !== want.half_out) begin
               $error("half_out expected %h actual %h", want.half_out,
                      rsp_ch.data.half_out);
               fail_count++;
            end
         end
      end
   end

   typedef struct {
      func_type    func;
      logic [31:0] operand;
      logic        known;
      logic [31:0] result;
   } vector_type;

   vector_type vectors[] = '{
      '{FUNC_H2S, 32'h0000, 1'b1, 32'h0000_0000},
      '{FUNC_H2S, 32'h8000, 1'b1, 32'h8000_0000},
      '{FUNC_H2S, 32'h7C00, 1'b1, 32'h7F80_0000},
      '{FUNC_H2S, 32'hFC00, 1'b1, 32'hFF80_0000},
      '{FUNC_H2S, 32'h7FFF, 1'b1, 32'h7FFF_E000},
      '{FUNC_H2S, 32'h3C00, 1'b1, 32'h3F80_0000},
      '{FUNC_H2S, 32'h0001, 1'b0, 32'h0},
      '{FUNC_H2S, 32'h83FF, 1'b0, 32'h0},
      '{FUNC_H2S, 32'h7BFF, 1'b0, 32'h0},
      '{FUNC_S2H, 32'h0000_0000, 1'b1, 32'h0000},
      '{FUNC_S2H, 32'h8000_0001, 1'b1, 32'h8000},
      '{FUNC_S2H, 32'h7F80_0000, 1'b1, 32'h7C00},
      '{FUNC_S2H, 32'hFFFF_FFFF, 1'b1, 32'hFE00},
      '{FUNC_S2H, 32'h7F80_0001, 1'b1, 32'h7E00},
      '{FUNC_S2H, 32'h7F7F_FFFF, 1'b1, 32'h7C00},
      '{FUNC_S2H, 32'h477F_F000, 1'b1, 32'h7C00},
      '{FUNC_S2H, 32'h477F_EFFF, 1'b0, 32'h0},
      '{FUNC_S2H, 32'h3F80_0000, 1'b1, 32'h3C00},
      '{FUNC_S2H, 32'h3F80_1000, 1'b1, 32'h3C00},
      '{FUNC_S2H, 32'h3F80_3000, 1'b0, 32'h0},
      '{FUNC_S2H, 32'h3300_0000, 1'b1, 32'h0000},
      '{FUNC_S2H, 32'h3300_0001, 1'b1, 32'h0001},
      '{FUNC_S2H, 32'h387F_F000, 1'b0, 32'h0},
      '{FUNC_S2H, 32'h3380_0000, 1'b0, 32'h0}
   };

   task automatic send_request(req_type r, logic known, rsp_type want);
      while (!quiet_stretch && $urandom_range(99) < 23) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data  <= r;
      conv_expected_q.push_back(known ? want : convert(r));
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   function automatic req_type random_request();
      req_type r;
      logic [7:0] e8;
      r.func      = 1'($urandom_range(1));
      r.half_in   = 16'($urandom);
      r.single_in = $urandom;
      if (r.single_in[0] == 0) begin
         // bias exponent toward the half range and its edges
         e8 = 8'($urandom_range(100, 145));
         r.single_in[30:23] = e8;
         if ($urandom_range(3) == 0) r.single_in[12:0] = 13'h1000;
      end
      return r;
   endfunction

   initial begin
      req_type r;
      rsp_type want;
      fail_count    = 0;
      rsp_count     = 0;
      quiet_stretch = 1'b0;
      reset         = 1'b1;
      req_ch.valid  = 1'b0;
      req_ch.data   = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (vectors[i]) begin
         r = '0;
         want = '0;
         r.func = vectors[i].func;
         if (vectors[i].func == FUNC_H2S) begin
            r.half_in = vectors[i].operand[15:0];
            r.single_in = $urandom;
            want.single_out = vectors[i].result;
         end else begin
            r.single_in = vectors[i].operand;
            r.half_in = 16'($urandom);
            want.half_out = vectors[i].result[15:0];
         end
         send_request(r, vectors[i].known, want);
      end
      for (int i = 0; i < NumRandom; i++) begin
         quiet_stretch = (i >= 500 && i < 650);
         send_request(random_request(), 1'b0, '0);
      end
      req_ch.valid <= 1'b0;
      while (conv_expected_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      $display("covered %0d directed and %0d random conversions, both directions,",
               vectors.size(), NumRandom);
      $display("%0d responses checked, with a long response stall", rsp_count);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/hsfc_pkg.sv
rtl/hsfc_if.sv
rtl/half_single_float_converter.sv
tb/tb_top.sv
